[hdl/ece_pkg.sv]
// Shared types and constants for the easing curve evaluator.
// Used by ece_kernel and easing_curve_evaluator; depends on nothing.
`default_nettype none

package ece_pkg;

   localparam int MODE_W    = 3;
   localparam int VARIANT_W = 2;
   localparam int TIME_W    = 16;
   localparam int CSR_W     = 16;
   localparam int OUT_W     = 17;

   // curve kinds
   localparam logic [MODE_W-1:0] MODE_LINEAR = 3'd0;
   localparam logic [MODE_W-1:0] MODE_QUAD   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CUBIC  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_QUART  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_QUINT  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_BACK   = 3'd5;
   localparam logic [MODE_W-1:0] MODE_BOUNCE = 3'd6;

   // variants; both remaining codes mean in-out
   localparam logic [VARIANT_W-1:0] VARIANT_IN     = 2'd0;
   localparam logic [VARIANT_W-1:0] VARIANT_OUT    = 2'd1;
   localparam logic [VARIANT_W-1:0] VARIANT_IN_OUT = 2'd2;

   // overshoot 1.70158 in Q2.14
   localparam logic [CSR_W-1:0] OVERSHOOT_RESET = 16'd27879;
   localparam int OVERSHOOT_FRAC = 14;

   // in-out overshoot: v * 61 / 40, rounded; 40 * 2^14 = 5 * 2^17
   localparam int IO_SCALE = 61;
   localparam int IO_ROUND = 327680;
   localparam int IO_SHIFT = 17;
   localparam int IO_DIV   = 5;
   // floor(2^32 / 5), quotient is exact or one low for dividends below 2^30
   localparam logic [29:0] RECIP_5     = 30'd858993459;
   localparam int          RECIP_SHIFT = 32;

   typedef enum logic [1:0] {
      PHASE_IN,
      PHASE_OUT,
      PHASE_IO_LO,
      PHASE_IO_HI
   } ece_phase_type;

   typedef struct packed {
      logic                valid;
      logic [MODE_W-1:0]   mode;
      ece_phase_type       phase;
   } ece_ctl_type;

endpackage

`default_nettype wire

[hdl/ece_kernel.sv]
// Six-stage ease-in kernel pipeline: powers x^2..x^5, back curve and bounce arc.
// Depends on ece_pkg.
`default_nettype none

module ece_kernel import ece_pkg::*; #(
   parameter int TIME_FRAC_BITS = 15
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ece_ctl_type                  in_ctl,
   input  wire logic [TIME_FRAC_BITS:0]      in_x,
   input  wire logic [TIME_FRAC_BITS+2:0]    s_std,
   input  wire logic [TIME_FRAC_BITS+2:0]    s_io,
   output ece_ctl_type                       out_ctl,
   output logic signed [TIME_FRAC_BITS+4:0]  out_kernel
);

   localparam int F  = TIME_FRAC_BITS;
   localparam int XW = F + 1;   // x and powers, at most ONE
   localparam int SW = F + 3;   // overshoot
   localparam int AW = F + 4;   // (s+1)*x
   localparam int MW = F + 4;   // |a - s|
   localparam int KW = F + 5;   // kernel, signed
   localparam int YW = F + 3;   // bounce offset from arc center

   localparam logic [XW-1:0]     ONE   = XW'(1) << F;
   localparam logic [2*XW-1:0]   RND_X = (2*XW)'(1) << (F - 1);
   localparam logic [2*YW-1:0]   RND_Y = (2*YW)'(1) << (F + 5);
   localparam logic [AW+XW-1:0]  RND_A = (AW+XW)'(1) << (F - 1);
   localparam logic [MW+XW-1:0]  RND_M = (MW+XW)'(1) << (F - 1);

   // bounce breaks on 11z and arc centers on 22z
   localparam logic [XW+3:0] BRK_4  = (XW+4)'(4)  << F;
   localparam logic [XW+3:0] BRK_8  = (XW+4)'(8)  << F;
   localparam logic [XW+3:0] BRK_10 = (XW+4)'(10) << F;
   localparam logic [XW+4:0] CTR_12 = (XW+5)'(12) << F;
   localparam logic [XW+4:0] CTR_18 = (XW+5)'(18) << F;
   localparam logic [XW+4:0] CTR_21 = (XW+5)'(21) << F;
   localparam logic [XW-1:0] LIFT_48 = XW'(48) << (F - 6);
   localparam logic [XW-1:0] LIFT_60 = XW'(60) << (F - 6);
   localparam logic [XW-1:0] LIFT_63 = XW'(63) << (F - 6);

   ece_ctl_type ctl_st2_ff, ctl_st3_ff, ctl_st4_ff, ctl_st5_ff, ctl_st6_ff, ctl_st7_ff;

   logic [XW-1:0] x_st2_ff, x_st3_ff, x_st4_ff, x_st5_ff, x_st6_ff;
   logic [XW-1:0] x2_st2_ff, x2_st3_ff, x2_st4_ff, x2_st5_ff, x2_st6_ff;
   logic [XW-1:0] x3_st3_ff, x3_st4_ff, x3_st5_ff, x3_st6_ff;
   logic [XW-1:0] x4_st4_ff, x4_st5_ff, x4_st6_ff;
   logic [XW-1:0] x5_st5_ff, x5_st6_ff;
   logic [YW-1:0] y_st2_ff;
   logic [XW-1:0] lift_st2_ff, lift_st3_ff;
   logic [XW-1:0] arc_st3_ff;
   logic signed [KW-1:0] kb_st4_ff, kb_st5_ff, kb_st6_ff;
   logic [AW-1:0] a_st5_ff;
   logic [MW-1:0] mag_st6_ff;
   logic          neg_st6_ff;
   logic signed [KW-1:0] kernel_st7_ff;

   // stage 2: x^2, bounce arc choice
   logic [2*XW-1:0] sq_x;
   logic [XW-1:0]   x2_in;
   logic [XW-1:0]   z;
   logic [XW+3:0]   z11;
   logic [XW+4:0]   z22;
   logic [XW+4:0]   ctr;
   logic [XW-1:0]   lift_in;
   logic [YW-1:0]   y_in;

   assign sq_x  = (2*XW)'(in_x) * (2*XW)'(in_x);
   assign x2_in = XW'((sq_x + RND_X) >> F);
   assign z     = ONE - in_x;
   assign z11   = (XW+4)'(z) * (XW+4)'(11);
   assign z22   = (XW+5)'(z) * (XW+5)'(22);

   always_comb begin
      if (z11 < BRK_4) begin
         ctr     = '0;
         lift_in = '0;
      end else if (z11 < BRK_8) begin
         ctr     = CTR_12;
         lift_in = LIFT_48;
      end else if (z11 < BRK_10) begin
         ctr     = CTR_18;
         lift_in = LIFT_60;
      end else begin
         ctr     = CTR_21;
         lift_in = LIFT_63;
      end
      y_in = (z22 >= ctr) ? YW'(z22 - ctr) : YW'(ctr - z22);
   end

   // stage 3: x^3, arc square
   logic [2*XW-1:0] p3;
   logic [XW-1:0]   x3_in;
   logic [2*YW-1:0] sq_y;
   logic [XW-1:0]   arc_in;

   assign p3     = (2*XW)'(x2_st2_ff) * (2*XW)'(x_st2_ff);
   assign x3_in  = XW'((p3 + RND_X) >> F);
   assign sq_y   = (2*YW)'(y_st2_ff) * (2*YW)'(y_st2_ff);
   assign arc_in = XW'((sq_y + RND_Y) >> (F + 6));

   // stage 4: x^4, bounce kernel = 1 - B
   logic [2*XW-1:0]      p4;
   logic [XW-1:0]        x4_in;
   logic [XW:0]          b_sum;
   logic signed [KW-1:0] kb_in;

   assign p4    = (2*XW)'(x3_st3_ff) * (2*XW)'(x_st3_ff);
   assign x4_in = XW'((p4 + RND_X) >> F);
   assign b_sum = (XW+1)'(arc_st3_ff) + (XW+1)'(lift_st3_ff);
   assign kb_in = $signed(KW'(ONE)) - $signed(KW'(b_sum));

   // the overshoot doubles as a per-item value: in-out items use the scaled one
   function automatic logic [SW-1:0] pick_s(input ece_phase_type ph,
                                            input logic [SW-1:0] s_a,
                                            input logic [SW-1:0] s_b);
      logic [SW-1:0] r;
      r = (ph == PHASE_IN || ph == PHASE_OUT) ? s_a : s_b;
      return r;
   endfunction

   // stage 5: x^5, a = (s+1)*x
   logic [2*XW-1:0]    p5;
   logic [XW-1:0]      x5_in;
   logic [SW-1:0]      s_st4;
   logic [AW-1:0]      s_plus;
   logic [AW+XW-1:0]   pa;
   logic [AW-1:0]      a_in;

   assign p5     = (2*XW)'(x4_st4_ff) * (2*XW)'(x_st4_ff);
   assign x5_in  = XW'((p5 + RND_X) >> F);
   assign s_st4  = pick_s(ctl_st4_ff.phase, s_std, s_io);
   assign s_plus = AW'(s_st4) + AW'(ONE);
   assign pa     = (AW+XW)'(s_plus) * (AW+XW)'(x_st4_ff);
   assign a_in   = AW'((pa + RND_A) >> F);

   // stage 6: inner = a - s as sign and magnitude
   logic [SW-1:0]        s_st5;
   logic signed [KW-1:0] inner;
   logic                 neg_in;
   logic [MW-1:0]        mag_in;

   assign s_st5  = pick_s(ctl_st5_ff.phase, s_std, s_io);
   assign inner  = $signed(KW'(a_st5_ff)) - $signed(KW'(s_st5));
   assign neg_in = inner[KW-1];
   assign mag_in = neg_in ? MW'(-inner) : MW'(inner);

   // stage 7: back product, kernel select
   logic [MW+XW-1:0]     pb;
   logic [MW-1:0]        back_mag;
   logic signed [KW-1:0] back;
   logic signed [KW-1:0] kernel_in;

   assign pb       = (MW+XW)'(mag_st6_ff) * (MW+XW)'(x2_st6_ff);
   assign back_mag = MW'((pb + RND_M) >> F);
   assign back     = neg_st6_ff ? -$signed(KW'(back_mag)) : $signed(KW'(back_mag));

   always_comb begin
      case (ctl_st6_ff.mode)
         MODE_QUAD:   kernel_in = $signed(KW'(x2_st6_ff));
         MODE_CUBIC:  kernel_in = $signed(KW'(x3_st6_ff));
         MODE_QUART:  kernel_in = $signed(KW'(x4_st6_ff));
         MODE_QUINT:  kernel_in = $signed(KW'(x5_st6_ff));
         MODE_BACK:   kernel_in = back;
         MODE_BOUNCE: kernel_in = kb_st6_ff;
         default:     kernel_in = $signed(KW'(x_st6_ff));
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_st2_ff <= '0;
         ctl_st3_ff <= '0;
         ctl_st4_ff <= '0;
         ctl_st5_ff <= '0;
         ctl_st6_ff <= '0;
         ctl_st7_ff <= '0;
      end else begin
         ctl_st2_ff <= in_ctl;
         ctl_st3_ff <= ctl_st2_ff;
         ctl_st4_ff <= ctl_st3_ff;
         ctl_st5_ff <= ctl_st4_ff;
         ctl_st6_ff <= ctl_st5_ff;
         ctl_st7_ff <= ctl_st6_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_st2_ff    <= in_x;
      x2_st2_ff   <= x2_in;
      y_st2_ff    <= y_in;
      lift_st2_ff <= lift_in;

      x_st3_ff    <= x_st2_ff;
      x2_st3_ff   <= x2_st2_ff;
      x3_st3_ff   <= x3_in;
      arc_st3_ff  <= arc_in;
      lift_st3_ff <= lift_st2_ff;

      x_st4_ff    <= x_st3_ff;
      x2_st4_ff   <= x2_st3_ff;
      x3_st4_ff   <= x3_st3_ff;
      x4_st4_ff   <= x4_in;
      kb_st4_ff   <= kb_in;

      x_st5_ff    <= x_st4_ff;
      x2_st5_ff   <= x2_st4_ff;
      x3_st5_ff   <= x3_st4_ff;
      x4_st5_ff   <= x4_st4_ff;
      x5_st5_ff   <= x5_in;
      kb_st5_ff   <= kb_st4_ff;
      a_st5_ff    <= a_in;

      x_st6_ff    <= x_st5_ff;
      x2_st6_ff   <= x2_st5_ff;
      x3_st6_ff   <= x3_st5_ff;
      x4_st6_ff   <= x4_st5_ff;
      x5_st6_ff   <= x5_st5_ff;
      kb_st6_ff   <= kb_st5_ff;
      mag_st6_ff  <= mag_in;
      neg_st6_ff  <= neg_in;

      kernel_st7_ff <= kernel_in;
   end

   assign out_ctl    = ctl_st7_ff;
   assign out_kernel = kernel_st7_ff;

endmodule

`default_nettype wire

[hdl/easing_curve_evaluator.sv]
// Easing curve evaluator: time folding, overshoot derivation, variant assembly.
// Depends on ece_pkg and ece_kernel.
// An accepted beat passes the time fold register, the kernel pipeline and the output register in order.
// Throughput: one beat per cycle; busy is never raised.
// Reset: synchronous, clears all valid bits and loads overshoot 1.70158.
// The scaled in-out overshoot follows a csr write through m_ff, then q0_ff and m_d_ff, then s_io_ff.
`default_nettype none

module easing_curve_evaluator import ece_pkg::*; #(
   parameter int TIME_FRAC_BITS = 15
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [MODE_W-1:0]     req_mode,
   input  wire logic [VARIANT_W-1:0]  req_variant,
   input  wire logic [TIME_W-1:0]     req_time_req,
   output logic                       rsp_valid,
   output logic signed [OUT_W-1:0]    rsp_eased_value,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_W-1:0]      csr_wr_data
);

   localparam int F  = TIME_FRAC_BITS;
   localparam int XW = F + 1;
   localparam int SW = F + 3;
   localparam int KW = F + 5;
   localparam int RW = KW + 2;
   localparam int CW = F + 17;
   localparam int NW = F + 23;
   localparam int MQ = F + 6;    // dividend of the divide by five
   localparam int QW = F + 4;
   localparam int PW = MQ + 30;

   localparam logic [CW-1:0] ONE_C  = CW'(1) << F;
   localparam logic [CW-1:0] HALF_C = CW'(1) << (F - 1);
   localparam logic [XW-1:0] ONE_X  = XW'(1) << F;

   localparam int ONE_I = 1 << F;
   localparam int LO_I  = (2 * ONE_I > 65536) ? -65536 : -2 * ONE_I;
   localparam int HI_I  = (2 * ONE_I - 1 > 65535) ? 65535 : 2 * ONE_I - 1;
   localparam logic signed [RW-1:0] LO_R  = RW'(LO_I);
   localparam logic signed [RW-1:0] HI_R  = RW'(HI_I);
   localparam logic signed [RW-1:0] ONE_R = RW'(ONE_I);

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // ---------------- overshoot register and derived values
   logic [CSR_W-1:0] overshoot_ff;
   logic [SW-1:0]    s_std_ff, s_std_in;
   logic [MQ-1:0]    m_ff, m_in, m_d_ff;
   logic [QW-1:0]    q0_ff, q0_in;
   logic [SW-1:0]    s_io_ff, s_io_in;

   logic [CW-1:0] std_wide;
   logic [21:0]   v61;
   logic [NW-1:0] n_wide;
   logic [PW-1:0] q_prod;
   logic [MQ-1:0] rem;

   assign std_wide = (CW'(overshoot_ff) << F) + (CW'(1) << (OVERSHOOT_FRAC - 1));
   assign s_std_in = SW'(std_wide >> OVERSHOOT_FRAC);
   assign v61      = 22'(overshoot_ff) * 22'(IO_SCALE);
   assign n_wide   = (NW'(v61) << F) + NW'(IO_ROUND);
   assign m_in     = MQ'(n_wide >> IO_SHIFT);
   assign q_prod   = PW'(m_ff) * PW'(RECIP_5);
   assign q0_in    = QW'(q_prod >> RECIP_SHIFT);
   // reciprocal quotient is exact or one short
   assign rem      = m_d_ff - MQ'(q0_ff) * MQ'(IO_DIV);
   assign s_io_in  = SW'(q0_ff + QW'(rem >= MQ'(IO_DIV)));

   always_ff @(posedge clock) begin
      if (reset) begin
         overshoot_ff <= OVERSHOOT_RESET;
      end else if (csr_wr_en) begin
         overshoot_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      s_std_ff <= s_std_in;
      m_ff     <= m_in;
      m_d_ff   <= m_ff;
      q0_ff    <= q0_in;
      s_io_ff  <= s_io_in;
   end

   // ---------------- stage 1: saturate time, fold variant into kernel argument
   ece_ctl_type   ctl_st1_ff, ctl_st1_in;
   logic [XW-1:0] x_st1_ff, x_st1_in;
   logic [CW-1:0] t_ext, tc;
   logic [XW-1:0] tc_x;

   assign t_ext = CW'(req_time_req);
   assign tc    = (t_ext > ONE_C) ? ONE_C : t_ext;
   assign tc_x  = XW'(tc);

   always_comb begin
      ctl_st1_in.valid = accept;
      ctl_st1_in.mode  = req_mode;
      case (req_variant)
         VARIANT_IN: begin
            ctl_st1_in.phase = PHASE_IN;
            x_st1_in         = tc_x;
         end
         VARIANT_OUT: begin
            ctl_st1_in.phase = PHASE_OUT;
            x_st1_in         = ONE_X - tc_x;
         end
         default: begin
            if (tc < HALF_C) begin
               ctl_st1_in.phase = PHASE_IO_LO;
               x_st1_in         = XW'(tc << 1);
            end else begin
               ctl_st1_in.phase = PHASE_IO_HI;
               x_st1_in         = XW'((ONE_C - tc) << 1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_st1_ff <= '0;
      end else begin
         ctl_st1_ff <= ctl_st1_in;
      end
   end

   always_ff @(posedge clock) begin
      x_st1_ff <= x_st1_in;
   end

   // ---------------- stages 2..7: kernel
   ece_ctl_type          ctl_k;
   logic signed [KW-1:0] kernel;

   ece_kernel #(
      .TIME_FRAC_BITS (TIME_FRAC_BITS)
   ) u_kernel (
      .clock      (clock),
      .reset      (reset),
      .in_ctl     (ctl_st1_ff),
      .in_x       (x_st1_ff),
      .s_std      (s_std_ff),
      .s_io       (s_io_ff),
      .out_ctl    (ctl_k),
      .out_kernel (kernel)
   );

   // ---------------- stage 8: variant assembly and saturation
   logic                 rsp_valid_ff;
   logic signed [OUT_W-1:0] eased_ff, eased_in;
   logic signed [RW-1:0] k_r, k_mag, k_half_mag, k_half, r_val, r_sat;
   logic                 k_neg;

   assign k_r        = RW'(kernel);
   assign k_neg      = k_r[RW-1];
   assign k_mag      = k_neg ? -k_r : k_r;
   assign k_half_mag = (k_mag + RW'(1)) >>> 1;
   assign k_half     = k_neg ? -k_half_mag : k_half_mag;

   always_comb begin
      case (ctl_k.phase)
         PHASE_IN:    r_val = k_r;
         PHASE_OUT:   r_val = ONE_R - k_r;
         PHASE_IO_LO: r_val = k_half;
         PHASE_IO_HI: r_val = ONE_R - k_half;
         default:     r_val = k_r;
      endcase
      if (r_val < LO_R) begin
         r_sat = LO_R;
      end else if (r_val > HI_R) begin
         r_sat = HI_R;
      end else begin
         r_sat = r_val;
      end
   end

   assign eased_in = OUT_W'(r_sat);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl_k.valid;
      end
   end

   always_ff @(posedge clock) begin
      eased_ff <= eased_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_eased_value = eased_ff;

`ifndef SYNTHESIS
   a_beat_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##8 rsp_valid)
      else $error("accepted beat did not produce a result on time");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 8))
      else $error("result without a matching accepted beat");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_eased_value) >= LO_I && int'(rsp_eased_value) <= HI_I))
      else $error("result outside the saturation range");

   a_poly_end: assert property (@(posedge clock) disable iff (reset)
      (accept && int'(req_time_req) >= ONE_I && req_variant == VARIANT_IN
       && req_mode <= MODE_QUINT) |-> ##8 (int'(rsp_eased_value) == ONE_I))
      else $error("polynomial ease-in does not reach one at the end of time");
`endif

endmodule

`default_nettype wire
